// ----- src/tcw_pkg.sv -----
// Shared constants, payload types and control structs for the text console writer.
`default_nettype none

package tcw_pkg;

    // Screen geometry and tab spacing
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_STOP       = 4;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    // Internal widths
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int PH_W   = $clog2(TAB_STOP + 1);
    localparam int REM_W  = $clog2(TAB_STOP + 1);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(TAB_STOP - 1);
    localparam logic [REM_W-1:0]  REM_ONE   = REM_W'(1);
    localparam logic [REM_W-1:0]  REM_TAB   = REM_W'(TAB_STOP);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);

    // Command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [7:0] RESET_COLOR = 8'd7;

    // Input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
        logic [7:0]  read_char;
        logic [7:0]  read_color;
    } t_out_item;

    // Cell store access from the sequencer
    typedef struct packed {
        logic              we_char;
        logic              we_color;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wchar;
        logic [7:0]        wcolor;
        logic [ADDR_W-1:0] raddr;
    } t_mem_cmd;

    // Sequencer status
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

endpackage

`default_nettype wire

// ----- src/text_console_writer.sv -----
// Top level of the text console writer: handshakes, color register, cell store, sequencer.
//
// An 80x25 text console with a cursor; each beat in gives one beat out carrying the
// cursor after the command. Items are handled one at a time through a sequencer that
// drives a cell store with one write and one read port per cycle, so that port sets
// the timing. A tab stores spaces up to the next tab stop (at most TAB_STOP); a scroll
// copies every row up by one row and blanks the bottom row, and a clear command blanks
// every cell. After reset the store is swept to blanks before the first beat is
// accepted; color writes are taken at any time. A finished result sits in an output
// register so a stall on the output holds it while the next beat can already be
// accepted.
`default_nettype none

module text_console_writer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire tcw_pkg::t_in_item  i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      tcw_pkg::t_out_item o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_wdata
);

    import tcw_pkg::*;

    logic        r_default_color_v;
    logic [7:0]  r_default_color;
    logic        r_out_valid;
    t_out_item   r_out_data;
    t_mem_cmd    mem;
    t_eng_stat   stat;
    t_out_item   res;
    logic [7:0]  rd_char;
    logic [7:0]  rd_color;
    logic        in_accept;
    logic        out_free;
    logic        res_load;

    // Handshakes
    assign o_in_stall = !stat.idle;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign res_load   = stat.res_valid && out_free;

    // Default color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color   <= RESET_COLOR;
            r_default_color_v <= 1'b0;
        end else if (i_cfg_we) begin
            r_default_color   <= i_cfg_wdata;
            r_default_color_v <= 1'b1;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tcw_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (in_accept),
        .i_item          (i_in_data),
        .i_default_color (r_default_color),
        .i_res_taken     (res_load),
        .i_rd_char       (rd_char),
        .i_rd_color      (rd_color),
        .o_mem           (mem),
        .o_stat          (stat),
        .o_res           (res)
    );

    // Character plane
    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELL_COUNT)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_char),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wchar),
        .i_raddr (mem.raddr),
        .o_rdata (rd_char)
    );

    // Color plane
    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELL_COUNT)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we_color),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wcolor),
        .i_raddr (mem.raddr),
        .o_rdata (rd_color)
    );

    // An accepted beat makes the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !stat.idle)
        else $error("sequencer idle right after accepting a beat");

    // A held result is never overwritten while the output is stalled
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_out_data) && r_out_valid))
        else $error("stalled result changed");

    // Reported cursor always lies on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (32'(r_out_data.cursor_column) < SCREEN_COLUMNS
                         && 32'(r_out_data.cursor_row) < SCREEN_ROWS))
        else $error("cursor off screen");

    // A color write is held in the register on the next cycle
    a_color_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_default_color == $past(i_cfg_wdata) && r_default_color_v))
        else $error("color write lost");

endmodule

`default_nettype wire

// ----- src/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/tcw_engine.sv -----
// Sequencer of the console: cursor state, tab expansion, scroll copy and clear sweeps.
`default_nettype none

module tcw_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire tcw_pkg::t_in_item    i_item,
    input  wire logic [7:0]           i_default_color,
    input  wire logic                 i_res_taken,
    input  wire logic [7:0]           i_rd_char,
    input  wire logic [7:0]           i_rd_color,
    output      tcw_pkg::t_mem_cmd    o_mem,
    output      tcw_pkg::t_eng_stat   o_stat,
    output      tcw_pkg::t_out_item   o_res
);

    import tcw_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PUT       = 3'd1;
    localparam logic [2:0] S_SCROLL_CP = 3'd2;
    localparam logic [2:0] S_SCROLL_BL = 3'd3;
    localparam logic [2:0] S_CLEAR     = 3'd4;
    localparam logic [2:0] S_READ      = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [PH_W-1:0]   r_ph, n_ph;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_init, n_init;
    logic [7:0]        r_char, n_char;
    logic [7:0]        r_rd_char, n_rd_char;
    logic [7:0]        r_rd_color, n_rd_color;
    logic [ADDR_W-1:0] lin;

    // Cursor as a cell address
    assign lin = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);

    // Next state and cell store access
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_ph       = r_ph;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_init     = r_init;
        n_char     = r_char;
        n_rd_char  = r_rd_char;
        n_rd_color = r_rd_color;
        o_mem      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rd_char  = '0;
                    n_rd_color = '0;
                    case (i_item.cmd)
                        CMD_PUT: begin
                            if (i_item.char_code == CH_NEWLINE) begin
                                n_col = '0;
                                n_ph  = '0;
                                n_rem = '0;
                                if (r_row == ROW_LAST) begin
                                    n_cnt   = '0;
                                    n_state = S_SCROLL_CP;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_state = S_DONE;
                                end
                            end else if (i_item.char_code == CH_RETURN) begin
                                n_col   = '0;
                                n_ph    = '0;
                                n_state = S_DONE;
                            end else if (i_item.char_code == CH_TAB) begin
                                n_char  = CH_SPACE;
                                n_rem   = REM_TAB - REM_W'(r_ph);
                                n_state = S_PUT;
                            end else begin
                                n_char  = i_item.char_code;
                                n_rem   = REM_ONE;
                                n_state = S_PUT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_init  = 1'b0;
                            n_state = S_CLEAR;
                        end
                        CMD_READ: begin
                            // Out-of-range reads answer zero without touching the store
                            if (32'(i_item.cell_index) < CELL_COUNT) begin
                                o_mem.raddr = ADDR_W'(i_item.cell_index);
                                n_state     = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Store one character at the cursor and advance
            S_PUT: begin
                o_mem.we_char = 1'b1;
                o_mem.waddr   = lin;
                o_mem.wchar   = r_char;
                n_rem         = r_rem - 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    n_ph  = '0;
                    if (r_row == ROW_LAST) begin
                        n_cnt   = '0;
                        n_state = S_SCROLL_CP;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = (r_rem == REM_ONE) ? S_DONE : S_PUT;
                    end
                end else begin
                    n_col   = r_col + 1'b1;
                    n_ph    = (r_ph == PH_LAST) ? '0 : r_ph + 1'b1;
                    n_state = (r_rem == REM_ONE) ? S_DONE : S_PUT;
                end
            end

            // Move rows up: read one row ahead, write the previous read back
            S_SCROLL_CP: begin
                if (r_cnt != COPY_END) begin
                    o_mem.raddr = r_cnt + COLS_A;
                end
                if (r_cnt != '0) begin
                    o_mem.we_char  = 1'b1;
                    o_mem.we_color = 1'b1;
                    o_mem.waddr    = r_cnt - 1'b1;
                    o_mem.wchar    = i_rd_char;
                    o_mem.wcolor   = i_rd_color;
                end
                if (r_cnt == COPY_END) begin
                    n_state = S_SCROLL_BL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Blank the bottom row
            S_SCROLL_BL: begin
                o_mem.we_char  = 1'b1;
                o_mem.we_color = 1'b1;
                o_mem.waddr    = r_cnt;
                o_mem.wchar    = CH_SPACE;
                o_mem.wcolor   = i_default_color;
                if (r_cnt == CELL_LAST) begin
                    n_state = (r_rem == '0) ? S_DONE : S_PUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Blank every cell; after reset use the reset color
            S_CLEAR: begin
                o_mem.we_char  = 1'b1;
                o_mem.we_color = 1'b1;
                o_mem.waddr    = r_cnt;
                o_mem.wchar    = CH_SPACE;
                o_mem.wcolor   = r_init ? RESET_COLOR : i_default_color;
                if (r_cnt == CELL_LAST) begin
                    n_col   = '0;
                    n_row   = '0;
                    n_ph    = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // Capture the addressed cell
            S_READ: begin
                n_rd_char  = i_rd_char;
                n_rd_color = i_rd_color;
                n_state    = S_DONE;
            end

            // Hold the result until the output register takes it
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_col   <= '0;
            r_row   <= '0;
            r_ph    <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ph    <= n_ph;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_rd_char  <= n_rd_char;
        r_rd_color <= n_rd_color;
    end

    // Status and result
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    assign o_res.cursor_column = 7'(r_col);
    assign o_res.cursor_row    = 5'(r_row);
    assign o_res.cursor_linear = 11'(lin);
    assign o_res.read_char     = r_rd_char;
    assign o_res.read_color    = r_rd_color;

endmodule

`default_nettype wire
